>>> src/ilid_pkg.sv
// ----------------------------------------------------------------------------
// ilid_pkg: shared types and constants of the indexed list
// Operation codes, field widths, the cell command and the control states.
// ----------------------------------------------------------------------------
package ilid_pkg;

    // Default list capacity
    localparam int CAPACITY_DEF = 256;

    // Fixed field widths
    localparam int KIND_W  = 3;
    localparam int POS_W   = 10;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 9;

    // Operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_READ = 3'd0,
        KIND_HEAD = 3'd1,
        KIND_TAIL = 3'd2,
        KIND_AT   = 3'd3,
        KIND_DEL  = 3'd4
    } kind_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic                      load;   // an item was accepted this cycle
        logic                      ins;    // shift up and place value at pos
        logic                      del;    // shift down over pos
        logic                      rd;     // capture the entry at pos
        logic [POS_W-1:0]          pos;
        logic signed [VALUE_W-1:0] value;
    } cell_cmd_t;

    // Control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_OUT
    } state_t;

endpackage

>>> src/ilid_in_if.sv
// ----------------------------------------------------------------------------
// ilid_in_if: operation channel of the indexed list
// Valid/ready channel carrying one list operation per item.
// ----------------------------------------------------------------------------
interface ilid_in_if;

    logic                               valid;
    logic                               ready;
    logic [ilid_pkg::KIND_W-1:0]        kind;
    logic [ilid_pkg::POS_W-1:0]         position;
    logic signed [ilid_pkg::VALUE_W-1:0] value;

    modport source (output valid, output kind, output position, output value,
                    input ready);
    modport sink   (input valid, input kind, input position, input value,
                    output ready);

endinterface

>>> src/ilid_out_if.sv
// ----------------------------------------------------------------------------
// ilid_out_if: result channel of the indexed list
// Valid/ready channel carrying one result per operation.
// ----------------------------------------------------------------------------
interface ilid_out_if;

    logic                                valid;
    logic                                ready;
    logic signed [ilid_pkg::VALUE_W-1:0] read_value;
    logic                                accepted;
    logic [ilid_pkg::COUNT_W-1:0]        count;

    modport source (output valid, output read_value, output accepted, output count,
                    input ready);
    modport sink   (input valid, input read_value, input accepted, input count,
                    output ready);

endinterface

>>> src/ilid_cell.sv
// ----------------------------------------------------------------------------
// ilid_cell: one list position
// Holds one entry, shifts with its neighbors on insert and delete, and
// captures its entry for the read tree when its position is addressed.
// ----------------------------------------------------------------------------
module ilid_cell #(
    parameter int INDEX = 0
) (
    input  logic                                clk,
    input  ilid_pkg::cell_cmd_t                 cmd,
    input  logic signed [ilid_pkg::VALUE_W-1:0] left_entry,
    input  logic signed [ilid_pkg::VALUE_W-1:0] right_entry,
    output logic signed [ilid_pkg::VALUE_W-1:0] entry,
    output logic [ilid_pkg::VALUE_W-1:0]        rd_data
);

    localparam logic [ilid_pkg::POS_W-1:0] MY_POS = ilid_pkg::POS_W'(INDEX);

    logic signed [ilid_pkg::VALUE_W-1:0] entry_reg;
    logic signed [ilid_pkg::VALUE_W-1:0] entry_next;
    logic [ilid_pkg::VALUE_W-1:0]        rd_reg;
    logic [ilid_pkg::VALUE_W-1:0]        rd_next;
    logic                                at_pos;
    logic                                above_pos;

    assign at_pos    = (MY_POS == cmd.pos);
    assign above_pos = (MY_POS > cmd.pos);

    // Shift entries around the addressed position
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (at_pos)
                entry_next = cmd.value;
            else if (above_pos)
                entry_next = left_entry;
        end
        else if (cmd.del)
        begin
            if (at_pos || above_pos)
                entry_next = right_entry;
        end
    end

    // Offer the entry to the read tree, zero elsewhere
    always_comb
    begin
        rd_next = rd_reg;
        if (cmd.load)
            rd_next = (cmd.rd && at_pos) ? entry_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        rd_reg    <= rd_next;
    end

    assign entry   = entry_reg;
    assign rd_data = rd_reg;

endmodule

>>> src/ilid_or_tree.sv
// ----------------------------------------------------------------------------
// ilid_or_tree: registered OR reduction of the cell read outputs
// At most one leaf is nonzero; a binary tree with a register per node
// brings it to the root.
// ----------------------------------------------------------------------------
module ilid_or_tree #(
    parameter int N = ilid_pkg::CAPACITY_DEF,
    parameter int W = ilid_pkg::VALUE_W
) (
    input  logic         clk,
    input  logic [W-1:0] leaf [N],
    output logic [W-1:0] root
);

    localparam int LEVELS = $clog2(N);
    localparam int NP     = 1 << LEVELS;

    logic [W-1:0] node_reg [NP-1];

    // Build each internal node from its two children
    for (genvar k = 0; k < NP - 1; k++)
    begin : g_node
        logic [W-1:0] lo;
        logic [W-1:0] hi;

        if (2 * k + 1 >= NP - 1)
        begin : g_lo_leaf
            if (2 * k + 1 - (NP - 1) < N)
            begin : g_real
                assign lo = leaf[2 * k + 1 - (NP - 1)];
            end
            else
            begin : g_pad
                assign lo = '0;
            end
        end
        else
        begin : g_lo_node
            assign lo = node_reg[2 * k + 1];
        end

        if (2 * k + 2 >= NP - 1)
        begin : g_hi_leaf
            if (2 * k + 2 - (NP - 1) < N)
            begin : g_real
                assign hi = leaf[2 * k + 2 - (NP - 1)];
            end
            else
            begin : g_pad
                assign hi = '0;
            end
        end
        else
        begin : g_hi_node
            assign hi = node_reg[2 * k + 2];
        end

        always_ff @(posedge clk)
        begin
            node_reg[k] <= lo | hi;
        end
    end

    assign root = node_reg[0];

endmodule

>>> src/indexed_list_insert_delete_top.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_top: ordered list with indexed insert and delete
// One item is in flight at a time; a new item is taken only once the last
//   result has been taken. A read is collected by the registered OR tree.
// Inserts/deletes shift every cell at or above the position at once.
// Reset: count and control clear at once; entries stay undefined, no sweep.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_top #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    ilid_in_if.sink           in_ch,
    ilid_out_if.source        out_ch
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > ilid_pkg::POS_W) ? CNT_W + 1 : ilid_pkg::POS_W + 1;
    localparam int LEVELS = $clog2(CAPACITY);
    localparam int WAIT_W = $clog2(LEVELS + 1);

    ilid_pkg::state_t state_reg;
    ilid_pkg::state_t state_next;
    logic [WAIT_W-1:0] wait_reg;
    logic [WAIT_W-1:0] wait_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              ok_reg;
    logic              ok_next;
    logic              rd_ok_reg;
    logic              rd_ok_next;

    logic                take;
    ilid_pkg::cell_cmd_t cmd;
    logic [CMP_W-1:0]    cnt_ext;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    ins_pos;
    logic                not_full;
    logic                ins_op;
    logic                ins_ok;
    logic                del_ok;
    logic                rd_ok;

    logic signed [ilid_pkg::VALUE_W-1:0] entry_w [CAPACITY];
    logic [ilid_pkg::VALUE_W-1:0]        rd_w    [CAPACITY];
    logic [ilid_pkg::VALUE_W-1:0]        root_w;

    // Decode the operation against the current count
    assign take     = in_ch.valid && in_ch.ready;
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_ext  = CMP_W'(in_ch.position);
    assign not_full = (cnt_ext < CMP_W'(CAPACITY));

    always_comb
    begin
        ins_pos = pos_ext;
        ins_op  = 1'b0;
        rd_ok   = 1'b0;
        del_ok  = 1'b0;
        case (ilid_pkg::kind_t'(in_ch.kind))
            ilid_pkg::KIND_READ:
                rd_ok = (pos_ext < cnt_ext);
            ilid_pkg::KIND_HEAD:
            begin
                ins_op  = 1'b1;
                ins_pos = '0;
            end
            ilid_pkg::KIND_TAIL:
            begin
                ins_op  = 1'b1;
                ins_pos = cnt_ext;
            end
            ilid_pkg::KIND_AT:
                ins_op = 1'b1;
            ilid_pkg::KIND_DEL:
                del_ok = (pos_ext < cnt_ext);
            default:
                ins_op = 1'b0;
        endcase
    end

    assign ins_ok = ins_op && not_full && (ins_pos <= cnt_ext);

    // Broadcast the command to the cells
    always_comb
    begin
        cmd.load  = take;
        cmd.ins   = take && ins_ok;
        cmd.del   = take && del_ok;
        cmd.rd    = take && rd_ok;
        cmd.pos   = ins_ok ? ins_pos[ilid_pkg::POS_W-1:0] : in_ch.position;
        cmd.value = in_ch.value;
    end

    // Row of cells, each linked to its neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [ilid_pkg::VALUE_W-1:0] left_w;
        logic signed [ilid_pkg::VALUE_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_inner_l
            assign left_w = entry_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_inner_r
            assign right_w = entry_w[i+1];
        end

        ilid_cell #(
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entry_w[i]),
            .rd_data     (rd_w[i])
        );
    end

    // Collect the addressed entry
    ilid_or_tree #(
        .N (CAPACITY),
        .W (ilid_pkg::VALUE_W)
    ) u_tree (
        .clk  (clk),
        .leaf (rd_w),
        .root (root_w)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        case (state_reg)
            ilid_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ilid_pkg::ST_BUSY;
                    wait_next  = WAIT_W'(LEVELS);
                end
            end
            ilid_pkg::ST_BUSY:
            begin
                wait_next = wait_reg - WAIT_W'(1);
                if (wait_reg == WAIT_W'(1))
                    state_next = ilid_pkg::ST_OUT;
            end
            ilid_pkg::ST_OUT:
            begin
                if (out_ch.ready)
                    state_next = ilid_pkg::ST_IDLE;
            end
            default:
                state_next = ilid_pkg::ST_IDLE;
        endcase
    end

    // Result flags and count
    always_comb
    begin
        count_next = count_reg;
        ok_next    = ok_reg;
        rd_ok_next = rd_ok_reg;
        if (take)
        begin
            ok_next    = ins_ok || del_ok || rd_ok;
            rd_ok_next = rd_ok;
            if (ins_ok)
                count_next = count_reg + CNT_W'(1);
            else if (del_ok)
                count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ilid_pkg::ST_IDLE;
            wait_reg  <= '0;
            count_reg <= '0;
            ok_reg    <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            count_reg <= count_next;
            ok_reg    <= ok_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    // Channel outputs
    always_comb
    begin
        in_ch.ready       = (state_reg == ilid_pkg::ST_IDLE);
        out_ch.valid      = (state_reg == ilid_pkg::ST_OUT);
        out_ch.read_value = rd_ok_reg ? root_w : '1;
        out_ch.accepted   = ok_reg;
        out_ch.count      = ilid_pkg::COUNT_W'(count_reg);
    end

endmodule
